@@ rtl/core/triangle_strip_to_list_converter_defines.svh @@
// Assertion macros shared by the triangle strip to list converter RTL.
`ifndef TRIANGLE_STRIP_TO_LIST_CONVERTER_DEFINES_SVH
`define TRIANGLE_STRIP_TO_LIST_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSTLC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tstlc same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TSTLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tstlc next-cycle check failed");

`endif

@@ rtl/core/tstlc_pkg.sv @@
// Shared types and constants for the triangle strip to list converter.
package tstlc_pkg;

    localparam int FIELD_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIST_MODE     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEXED       = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESTART_INDEX = 2'd2;

    typedef struct packed {
        logic                   list_mode;
        logic                   indexed;
        logic [FIELD_WIDTH-1:0] restart_index;
    } cfg_t;

    // Packed so corner_a sits in the low bits
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] corner_c;
        logic [FIELD_WIDTH-1:0] corner_b;
        logic [FIELD_WIDTH-1:0] corner_a;
    } tri_t;

endpackage

@@ rtl/core/tstlc_cfg_regs.sv @@
// Configuration register file for the triangle strip to list converter.
module tstlc_cfg_regs (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [tstlc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [tstlc_pkg::FIELD_WIDTH-1:0]        cfg_data,
    output tstlc_pkg::cfg_t                          cfg
);
    import tstlc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.list_mode     <= 1'b0;
            cfg_reg.indexed       <= 1'b1;
            cfg_reg.restart_index <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LIST_MODE:     cfg_reg.list_mode     <= cfg_data[0];
                CFG_INDEXED:       cfg_reg.indexed       <= cfg_data[0];
                CFG_RESTART_INDEX: cfg_reg.restart_index <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/tstlc_assemble.sv @@
// Vertex window, strip parity and triangle forming logic.
module tstlc_assemble #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tstlc_pkg::cfg_t                     cfg,
    input  logic                                in_accept,
    input  logic [tstlc_pkg::FIELD_WIDTH-1:0]   in_index,
    input  logic                                in_last,
    output logic                                tri_emit,
    output tstlc_pkg::tri_t                     tri_out
);
    import tstlc_pkg::*;

    `include "triangle_strip_to_list_converter_defines.svh"

    logic [INDEX_WIDTH-1:0] older_reg, older_next;
    logic [INDEX_WIDTH-1:0] newer_reg, newer_next;
    logic [1:0]             fill_reg, fill_next;
    logic                   odd_reg, odd_next;
    logic [INDEX_WIDTH-1:0] pos_reg, pos_next;

    logic [INDEX_WIDTH-1:0] idx;
    logic                   is_restart;

    assign idx = cfg.indexed ? in_index[INDEX_WIDTH-1:0] : pos_reg;
    assign is_restart = cfg.indexed && (idx == cfg.restart_index[INDEX_WIDTH-1:0]);

    always_comb begin
        older_next = older_reg;
        newer_next = newer_reg;
        fill_next  = fill_reg;
        odd_next   = odd_reg;
        pos_next   = pos_reg + 1'b1;
        tri_emit   = 1'b0;
        tri_out.corner_a = FIELD_WIDTH'(older_reg);
        tri_out.corner_b = FIELD_WIDTH'(newer_reg);
        tri_out.corner_c = FIELD_WIDTH'(idx);

        if (cfg.list_mode) begin
            // plain triples: older, newer, current
            case (fill_reg)
                2'd0: begin
                    older_next = idx;
                    fill_next  = 2'd1;
                end
                2'd1: begin
                    newer_next = idx;
                    fill_next  = 2'd2;
                end
                default: begin
                    tri_emit  = 1'b1;
                    fill_next = 2'd0;
                end
            endcase
        end else if (is_restart) begin
            fill_next = 2'd0;
            odd_next  = 1'b0;
        end else if (fill_reg < 2'd2) begin
            older_next = newer_reg;
            newer_next = idx;
            fill_next  = fill_reg + 2'd1;
        end else begin
            tri_emit = 1'b1;
            if (odd_reg) begin
                // odd strip triangle: swap to keep winding
                tri_out.corner_a = FIELD_WIDTH'(newer_reg);
                tri_out.corner_b = FIELD_WIDTH'(older_reg);
            end
            older_next = newer_reg;
            newer_next = idx;
            odd_next   = ~odd_reg;
        end

        if (in_last) begin
            older_next = '0;
            newer_next = '0;
            fill_next  = 2'd0;
            odd_next   = 1'b0;
            pos_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg <= '0;
            newer_reg <= '0;
            fill_reg  <= 2'd0;
            odd_reg   <= 1'b0;
            pos_reg   <= '0;
        end else if (in_accept) begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            fill_reg  <= fill_next;
            odd_reg   <= odd_next;
            pos_reg   <= pos_next;
        end
    end

    `TSTLC_ASSERT_NOW(a_fill_range, aclk, aresetn, 1'b1, fill_reg != 2'd3)
    `TSTLC_ASSERT_NOW(a_emit_full, aclk, aresetn, tri_emit, fill_reg == 2'd2)
    `TSTLC_ASSERT_NEXT(a_last_clears, aclk, aresetn, in_accept && in_last,
        fill_reg == 2'd0 && pos_reg == '0 && !odd_reg)

endmodule

@@ rtl/core/tstlc_out_buf.sv @@
// Result register with one skid entry for the triangle output channel.
module tstlc_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tstlc_pkg::tri_t   push_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tstlc_pkg::tri_t   out_data
);
    import tstlc_pkg::*;

    `include "triangle_strip_to_list_converter_defines.svh"

    logic main_valid_reg;
    logic skid_valid_reg;
    tri_t main_reg;
    tri_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_valid_reg && !out_ready) begin
            if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_valid_reg && !out_ready) begin
            if (push) begin
                skid_reg <= push_data;
            end
        end else if (skid_valid_reg) begin
            main_reg <= skid_reg;
        end else if (push) begin
            main_reg <= push_data;
        end
    end

    `TSTLC_ASSERT_NOW(a_skid_needs_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    `TSTLC_ASSERT_NOW(a_no_push_when_full, aclk, aresetn, push, !skid_valid_reg)
    `TSTLC_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && out_ready,
        main_valid_reg && !skid_valid_reg)

endmodule

@@ rtl/core/triangle_strip_to_list_converter.sv @@
// Top level of the triangle strip to list converter (primitive assembly with restart).
//
// Usage:
//   s_axis carries one vertex index per transaction (tdata) and tlast on the
//   final index of a draw. m_axis carries one triangle per transaction, corners
//   packed in tdata as corner_a, corner_b, corner_c from bit 0 up.
//   The cfg channel writes list_mode (0), indexed (1) and restart_index (2);
//   it is always ready and should be written only while the block is idle.
//   A triangle is registered as the index that completes it is accepted,
//   into the skid entry if m_axis is held off. Throughput: one index per
//   cycle while the skid entry is empty; the window update is a single
//   registered step; the result register has a one-entry skid buffer.
//   Reset (aresetn low, synchronous): window, parity and position counter
//   clear, config returns to strip mode, indexed, restart index all ones.
//   Stall: if m_axis is held off, one more triangle lands in the skid entry;
//   s_axis_tready drops only while that entry is occupied, and indices that
//   form no triangle are still accepted until then.
//   After a transaction with tlast, the window and counters start over.
module triangle_strip_to_list_converter #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tstlc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tstlc_pkg::FIELD_WIDTH-1:0]       cfg_data,
    // index input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [31:0]                             s_axis_tdata,  // [31:0] index
    input  logic                                    s_axis_tlast,
    // triangle output stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [95:0]                             m_axis_tdata   // [31:0] corner_a,
                                                                   // [63:32] corner_b,
                                                                   // [95:64] corner_c
);
    import tstlc_pkg::*;

    cfg_t cfg;
    tri_t tri_next;
    tri_t tri_out;
    logic tri_emit;
    logic in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    tstlc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // window state advances only on accepted index transactions
    tstlc_assemble #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_index  (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .tri_emit  (tri_emit),
        .tri_out   (tri_next)
    );

    // a triangle is pushed only when its completing index is accepted
    tstlc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept && tri_emit),
        .push_data (tri_next),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (tri_out)
    );

    assign m_axis_tdata = tri_out;

endmodule

@@ test/tstlc_checker.sv @@
// Checker for the triangle strip to list converter: predicts triangles and compares results.
module tstlc_checker #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [tstlc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tstlc_pkg::FIELD_WIDTH-1:0]     cfg_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [31:0]                           s_axis_tdata,
    input  logic                                  s_axis_tlast,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [95:0]                           m_axis_tdata,
    output int                                    fail_count,
    output int                                    outstanding
);
    import tstlc_pkg::*;

    localparam logic [31:0] IDX_MASK =
        (INDEX_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << INDEX_WIDTH) - 32'd1);

    // register copies
    logic        list_mode;
    logic        indexed;
    logic [31:0] restart_index;

    // assembly window
    logic [31:0] older_corner;
    logic [31:0] newer_corner;
    logic [1:0]  window_fill;
    logic        odd_parity;
    logic [31:0] position;

    tri_t pending_triangles[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("  mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic clear_window();
        older_corner = '0;
        newer_corner = '0;
        window_fill  = '0;
        odd_parity   = 1'b0;
        position     = '0;
    endtask

    // one index in, at most one triangle queued
    task automatic assemble_index(input logic [31:0] raw, input logic lst);
        logic [31:0] vtx;
        tri_t        t;
        vtx = indexed ? (raw & IDX_MASK) : (position & IDX_MASK);
        if (list_mode) begin
            if (window_fill == 2'd0) begin
                older_corner = vtx;
                window_fill  = 2'd1;
            end else if (window_fill == 2'd1) begin
                newer_corner = vtx;
                window_fill  = 2'd2;
            end else begin
                t.corner_a = older_corner;
                t.corner_b = newer_corner;
                t.corner_c = vtx;
                pending_triangles.insert(pending_triangles.size(), t);
                window_fill = 2'd0;
            end
        end else if (indexed && vtx == (restart_index & IDX_MASK)) begin
            window_fill = 2'd0;
            odd_parity  = 1'b0;
        end else if (window_fill < 2'd2) begin
            older_corner = newer_corner;
            newer_corner = vtx;
            window_fill  = window_fill + 2'd1;
        end else begin
            // odd triangles swap the first two corners to keep winding
            t.corner_a = odd_parity ? newer_corner : older_corner;
            t.corner_b = odd_parity ? older_corner : newer_corner;
            t.corner_c = vtx;
            pending_triangles.insert(pending_triangles.size(), t);
            older_corner = newer_corner;
            newer_corner = vtx;
            odd_parity   = ~odd_parity;
        end
        position = (position + 32'd1) & IDX_MASK;
        if (lst)
            clear_window();
    endtask

    always @(posedge aclk) begin
        tri_t want;
        tri_t got;
        if (!aresetn) begin
            list_mode     = 1'b0;
            indexed       = 1'b1;
            restart_index = 32'hFFFF_FFFF;
            clear_window();
            pending_triangles.delete();
        end else begin
            // results first: a triangle never leaves on the edge its last index enters
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_triangles.size() == 0) begin
                    report("unexpected triangle corner_a", got.corner_a, 32'h0);
                end else begin
                    want = pending_triangles.pop_front();
                    if (got.corner_a !== want.corner_a)
                        report("corner_a", got.corner_a, want.corner_a);
                    if (got.corner_b !== want.corner_b)
                        report("corner_b", got.corner_b, want.corner_b);
                    if (got.corner_c !== want.corner_c)
                        report("corner_c", got.corner_c, want.corner_c);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LIST_MODE:     list_mode = cfg_data[0];
                    CFG_INDEXED:       indexed = cfg_data[0];
                    CFG_RESTART_INDEX: restart_index = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                assemble_index(s_axis_tdata, s_axis_tlast);
        end
        outstanding = pending_triangles.size();
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the triangle strip to list converter: clock, reset, stimulus, verdict.
module tb_top;
    import tstlc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 125;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_LIST_MODE;
    logic [FIELD_WIDTH-1:0]     cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] index
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // [31:0] corner_a, [63:32] corner_b, [95:64] corner_c

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    // traffic shaping, shared between the stimulus and the receiver
    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    int hold_cycles = 0;

    // restart marker currently programmed, so random indices can hit it
    logic [31:0] marker = 32'hFFFF_FFFF;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    triangle_strip_to_list_converter #(.INDEX_WIDTH(32)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tstlc_checker #(.INDEX_WIDTH(32)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Receiver: a requested hold-off wins, then random stalls, else always ready.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (receiver_gaps) begin
            m_axis_tready <= ($urandom_range(99) >= 20);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog; a hung handshake or lost triangle ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("triangle_strip_to_list_converter regression: fail");
            $finish;
        end
    end

    // One index transaction. Entered and left at a falling edge; valid stays
    // high on return so back-to-back transactions need no extra step.
    task automatic put_index(input logic [31:0] v, input logic lst);
        if (sender_gaps) begin
            while ($urandom_range(99) < 20) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= lst;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every predicted triangle is out. Restart
    // items emit nothing, and the idle wait after that also covers the result
    // register and the skid entry.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Program all three registers, back to back, with the block idle.
    task automatic set_mode(input logic lmode, input logic idx_on, input logic [31:0] rst_val);
        logic [FIELD_WIDTH-1:0] vals[3];
        logic [CFG_INDEX_WIDTH-1:0] regs[3];
        drain();
        regs[0] = CFG_LIST_MODE;     vals[0] = {31'd0, lmode};
        regs[1] = CFG_INDEXED;       vals[1] = {31'd0, idx_on};
        regs[2] = CFG_RESTART_INDEX; vals[2] = rst_val;
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        @(negedge aclk);
        marker = rst_val;
    endtask

    // Many small indices and the marker so restarts and repeats turn up, plus corner
    // values and full-width noise so every tdata bit toggles.
    function automatic logic [31:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return marker;
        else if (r < 50)
            return $urandom_range(15);
        else if (r < 60) begin
            case ($urandom_range(3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Random draws of random length, tlast on the final index. The phase may
    // end mid-draw, so the next register setting lands on a live window.
    // pause_at >= 0 makes the sender wait once for all results at that item.
    task automatic random_draws(input int count, input int pause_at);
        int sent;
        int draw_len;
        sent = 0;
        while (sent < count) begin
            draw_len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 15);
            for (int k = 0; k < draw_len && sent < count; k++) begin
                if (sent == pause_at)
                    drain();
                // occasional stray tlast breaks a draw early
                put_index(pick_index(), (k == draw_len - 1) || ($urandom_range(99) < 2));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset config: strip, indexed, marker all ones
        put_index(32'd0, 1'b0);
        put_index(32'd1, 1'b0);
        put_index(32'd2, 1'b0);           // even triangle
        put_index(32'd3, 1'b0);           // odd triangle, swapped
        put_index(32'd4, 1'b0);
        put_index(32'hFFFF_FFFF, 1'b0);   // restart after odd-length strip
        put_index(32'd5, 1'b0);
        put_index(32'hFFFF_FFFF, 1'b0);   // restart with one index held
        put_index(32'hFFFF_FFFE, 1'b0);
        put_index(32'h8000_0000, 1'b0);
        put_index(32'h7FFF_FFFF, 1'b0);   // new strip starts even again
        put_index(32'h1234_5678, 1'b1);   // last item that emits, then clear
        put_index(32'd10, 1'b0);
        put_index(32'd11, 1'b1);          // last with partial window

        // list mode: marker is an ordinary index
        set_mode(1'b1, 1'b1, 32'hFFFF_FFFF);
        put_index(32'hFFFF_FFFF, 1'b0);
        put_index(32'd0, 1'b0);
        put_index(32'hFFFF_FFFF, 1'b0);
        put_index(32'd7, 1'b0);
        put_index(32'd8, 1'b1);           // last mid-group drops the pair

        // non-indexed strip: positions replace the index, marker ignored
        set_mode(1'b0, 1'b0, 32'd0);
        put_index(32'hFFFF_FFFF, 1'b0);
        put_index(32'd0, 1'b0);
        put_index(32'hFFFF_FFFF, 1'b0);
        put_index(32'd0, 1'b0);
        put_index(32'h5555_AAAA, 1'b1);

        // random phases across register settings
        set_mode(1'b0, 1'b1, 32'd0);
        random_draws(PHASE_ITEMS, -1);

        // no idling anywhere, and a long receiver hold-off that backs up s_axis
        set_mode(1'b0, 1'b1, 32'd3);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        hold_cycles = 80;
        random_draws(PHASE_ITEMS, -1);
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;

        // list mode, with one sender pause until all triangles are out
        set_mode(1'b1, 1'b1, $urandom);
        random_draws(PHASE_ITEMS, PHASE_ITEMS / 2);

        set_mode(1'b0, 1'b0, 32'd5);
        random_draws(PHASE_ITEMS, -1);

        set_mode(1'b1, 1'b0, 32'hFFFF_FFFF);
        random_draws(PHASE_ITEMS, -1);

        set_mode(1'b0, 1'b1, 32'hFFFF_FFFF);
        hold_cycles = 50;
        random_draws(PHASE_ITEMS, -1);

        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        if (fail_count == 0 && outstanding == 0)
            $display("triangle_strip_to_list_converter regression: pass");
        else
            $display("triangle_strip_to_list_converter regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tstlc_pkg.sv
rtl/core/tstlc_cfg_regs.sv
rtl/core/tstlc_assemble.sv
rtl/core/tstlc_out_buf.sv
rtl/core/triangle_strip_to_list_converter.sv
test/tstlc_checker.sv
test/tb_top.sv
